/* hw/rtl/hds_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hds_pkg
// Shared types and constants for the hop distance search controller.
// ----------------------------------------------------------------------------
package hds_pkg;

  localparam int unsigned MAX_TTL_DEF      = 48;
  localparam int unsigned MAX_ANON_RUN_DEF = 3;
  localparam int unsigned SEEN_DEPTH_DEF   = 64;

  localparam logic [7:0] TYPE_ECHO  = 8'd0;
  localparam logic [7:0] TYPE_TIMEX = 8'd11;

  // anonymous run counter saturates at its all-ones value
  localparam int unsigned ANON_W = 4;
  localparam int unsigned PKT_W  = 16;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_RESULT = 1'b1
  } op_t;

  typedef enum logic {
    KIND_PROBE = 1'b0,
    KIND_DONE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FWD,
    PH_BACK
  } phase_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_EXEC,
    BS_SCAN,
    BS_POST
  } bstate_t;

  // classified input word, front to back
  typedef struct packed {
    logic        is_start;
    logic        anon;
    logic        is_echo;
    logic        is_timex;
    logic [7:0]  start_ttl;
    logic [31:0] src;
    logic [31:0] dst;
    logic        fixed_flow;
    logic        double_mode;
    logic [31:0] reply_addr;
    logic [3:0]  cost;
  } cmd_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       probe_ttl;
    logic             probe_double;
    logic             probe_fixed_flow;
    logic [31:0]      probe_src;
    logic [31:0]      probe_dst;
    logic [7:0]       hop_distance;
    logic [PKT_W-1:0] packets_sent;
  } res_t;

endpackage : hds_pkg
`default_nettype wire

/* hw/rtl/hds_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hds_in_if
// Input channel: start and probe-result words with valid/ready.
// ----------------------------------------------------------------------------
interface hds_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  start_ttl;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic        fixed_flow;
  logic        double_mode;
  logic        reply_anonymous;
  logic [31:0] reply_addr;
  logic [7:0]  reply_type;
  logic [3:0]  probe_cost;

  modport source (
    output valid, op, start_ttl, src_addr, dst_addr, fixed_flow, double_mode,
           reply_anonymous, reply_addr, reply_type, probe_cost,
    input  ready
  );

  modport sink (
    input  valid, op, start_ttl, src_addr, dst_addr, fixed_flow, double_mode,
           reply_anonymous, reply_addr, reply_type, probe_cost,
    output ready
  );
endinterface : hds_in_if
`default_nettype wire

/* hw/rtl/hds_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hds_out_if
// Result channel: probe requests and finished words with valid/ready.
// ----------------------------------------------------------------------------
interface hds_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  probe_ttl;
  logic        probe_double;
  logic        probe_fixed_flow;
  logic [31:0] probe_src;
  logic [31:0] probe_dst;
  logic [7:0]  hop_distance;
  logic [15:0] packets_sent;

  modport source (
    output valid, kind, probe_ttl, probe_double, probe_fixed_flow, probe_src,
           probe_dst, hop_distance, packets_sent,
    input  ready
  );

  modport sink (
    input  valid, kind, probe_ttl, probe_double, probe_fixed_flow, probe_src,
           probe_dst, hop_distance, packets_sent,
    output ready
  );
endinterface : hds_out_if
`default_nettype wire

/* hw/rtl/hds_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hds_front
// Accepts input words, classifies them and registers them for the queue.
// ----------------------------------------------------------------------------
module hds_front (
  input  logic          clk,
  input  logic          rst_n,
  hds_in_if.sink        in_chan,
  output logic          push_valid,
  output hds_pkg::cmd_t push_cmd,
  input  logic          push_ready
);
  import hds_pkg::*;

  logic valid_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;

  assign in_chan.ready = !valid_r || push_ready;
  assign push_valid    = valid_r;
  assign push_cmd      = cmd_r;

  always_comb begin
    cmd_nxt.is_start    = (op_t'(in_chan.op) == OP_START);
    cmd_nxt.anon        = in_chan.reply_anonymous;
    cmd_nxt.is_echo     = (in_chan.reply_type == TYPE_ECHO);
    cmd_nxt.is_timex    = (in_chan.reply_type == TYPE_TIMEX);
    cmd_nxt.start_ttl   = in_chan.start_ttl;
    cmd_nxt.src         = in_chan.src_addr;
    cmd_nxt.dst         = in_chan.dst_addr;
    cmd_nxt.fixed_flow  = in_chan.fixed_flow;
    cmd_nxt.double_mode = in_chan.double_mode;
    cmd_nxt.reply_addr  = in_chan.reply_addr;
    cmd_nxt.cost        = in_chan.probe_cost;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule : hds_front
`default_nettype wire

/* hw/rtl/hds_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hds_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module hds_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  hds_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output hds_pkg::cmd_t pop_cmd,
  input  logic          pop_ready
);
  import hds_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule : hds_queue
`default_nettype wire

/* hw/rtl/hds_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hds_back
// Search engine: phase/TTL tracking, seen-address scan, result register.
// ----------------------------------------------------------------------------
module hds_back #(
  parameter int unsigned MAX_TTL      = hds_pkg::MAX_TTL_DEF,
  parameter int unsigned MAX_ANON_RUN = hds_pkg::MAX_ANON_RUN_DEF,
  parameter int unsigned SEEN_DEPTH   = hds_pkg::SEEN_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  input  hds_pkg::cmd_t pop_cmd,
  output logic          pop_ready,
  hds_out_if.source     out_chan
);
  import hds_pkg::*;

  localparam int unsigned IDX_W = $clog2(SEEN_DEPTH);
  localparam int unsigned CNT_W = $clog2(SEEN_DEPTH + 1);

  bstate_t          state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       cur_ttl_r, cur_ttl_nxt;
  logic [7:0]       first_ttl_r, first_ttl_nxt;
  logic [ANON_W-1:0] anon_run_r, anon_run_nxt;
  logic [CNT_W-1:0] seen_count_r, seen_count_nxt;
  logic [7:0]       best_r, best_nxt;
  logic [PKT_W-1:0] pkt_r, pkt_nxt;
  logic [31:0]      src_r, src_nxt;
  logic [31:0]      dst_r, dst_nxt;
  logic             fixed_r, fixed_nxt;
  logic             dbl_r, dbl_nxt;
  cmd_t             cmd_r;
  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             pend_r, pend_nxt;
  logic [31:0]      rd_data_r;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_r, out_nxt;

  logic [31:0]      seen_mem [SEEN_DEPTH];
  logic             mem_we;
  logic [IDX_W-1:0] rd_idx;

  logic             do_pop;
  logic             scan_issue;
  logic             scan_hit;
  logic [PKT_W:0]   pkt_sum;
  logic [PKT_W-1:0] pkt_sat;
  logic [8:0]       ttl_inc;
  logic             ttl_over;
  logic [ANON_W-1:0] anon_inc;
  logic             emit_req;
  logic             emit_done;
  logic [7:0]       done_dist;

  assign pop_ready  = (state_r == BS_IDLE) && !out_valid_r;
  assign do_pop     = pop_valid && pop_ready;
  assign scan_issue = (state_r == BS_SCAN) && (scan_idx_r < seen_count_r);
  assign scan_hit   = (state_r == BS_SCAN) && pend_r && (rd_data_r == cmd_r.reply_addr);
  assign rd_idx     = scan_issue ? scan_idx_r[IDX_W-1:0] : '0;

  assign pkt_sum  = {1'b0, pkt_r} + (PKT_W+1)'(cmd_r.cost);
  assign pkt_sat  = pkt_sum[PKT_W] ? '1 : pkt_sum[PKT_W-1:0];
  assign ttl_inc  = {1'b0, cur_ttl_r} + 9'd1;
  assign ttl_over = (ttl_inc > 9'(MAX_TTL));
  assign anon_inc = (anon_run_r == '1) ? anon_run_r : anon_run_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE: begin
        if (do_pop) state_nxt = BS_EXEC;
      end
      BS_EXEC: begin
        if (!cmd_r.is_start && phase_r == PH_FWD && !cmd_r.anon) state_nxt = BS_SCAN;
        else state_nxt = BS_IDLE;
      end
      BS_SCAN: begin
        if (scan_hit) state_nxt = BS_IDLE;
        else if (!scan_issue) state_nxt = BS_POST;
      end
      BS_POST: begin
        state_nxt = BS_IDLE;
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  // search datapath and result
  always_comb begin
    phase_nxt      = phase_r;
    cur_ttl_nxt    = cur_ttl_r;
    first_ttl_nxt  = first_ttl_r;
    anon_run_nxt   = anon_run_r;
    seen_count_nxt = seen_count_r;
    best_nxt       = best_r;
    pkt_nxt        = pkt_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    fixed_nxt      = fixed_r;
    dbl_nxt        = dbl_r;
    scan_idx_nxt   = scan_idx_r;
    pend_nxt       = 1'b0;
    mem_we         = 1'b0;
    emit_req       = 1'b0;
    emit_done      = 1'b0;
    done_dist      = '0;

    unique case (state_r)
      BS_IDLE: ;
      BS_EXEC: begin
        if (cmd_r.is_start) begin
          cur_ttl_nxt    = cmd_r.start_ttl;
          first_ttl_nxt  = cmd_r.start_ttl;
          src_nxt        = cmd_r.src;
          dst_nxt        = cmd_r.dst;
          fixed_nxt      = cmd_r.fixed_flow;
          dbl_nxt        = cmd_r.double_mode;
          anon_run_nxt   = '0;
          seen_count_nxt = '0;
          best_nxt       = '0;
          pkt_nxt        = '0;
          phase_nxt      = PH_FWD;
          emit_req       = 1'b1;
        end else if (phase_r == PH_IDLE) begin
          emit_done = 1'b1;
        end else begin
          pkt_nxt = pkt_sat;
          if (phase_r == PH_FWD) begin
            if (cmd_r.anon) begin
              anon_run_nxt = anon_inc;
              if (anon_inc >= ANON_W'(MAX_ANON_RUN) || ttl_over) begin
                emit_done = 1'b1;
              end else begin
                cur_ttl_nxt = ttl_inc[7:0];
                emit_req    = 1'b1;
              end
            end else begin
              scan_idx_nxt = '0;
            end
          end else begin
            // backward: keep stepping down while echoes come back
            if (cmd_r.anon || !cmd_r.is_echo) begin
              emit_done = 1'b1;
              done_dist = best_r;
            end else begin
              best_nxt = cur_ttl_r;
              if (cur_ttl_r <= 8'd2) begin
                emit_done = 1'b1;
                done_dist = cur_ttl_r;
              end else begin
                cur_ttl_nxt = cur_ttl_r - 1'b1;
                emit_req    = 1'b1;
              end
            end
          end
        end
      end
      BS_SCAN: begin
        if (scan_issue) scan_idx_nxt = scan_idx_r + 1'b1;
        pend_nxt = scan_issue;
        if (scan_hit) begin
          // replier seen before: routing loop
          pend_nxt  = 1'b0;
          emit_done = 1'b1;
        end
      end
      BS_POST: begin
        if (seen_count_r != CNT_W'(SEEN_DEPTH)) begin
          mem_we         = 1'b1;
          seen_count_nxt = seen_count_r + 1'b1;
        end
        anon_run_nxt = '0;
        if (cmd_r.is_echo) begin
          best_nxt = cur_ttl_r;
          if (cur_ttl_r != first_ttl_r) begin
            emit_done = 1'b1;
            done_dist = cur_ttl_r;
          end else if (first_ttl_r <= 8'd2) begin
            emit_done = 1'b1;
            done_dist = first_ttl_r;
          end else begin
            cur_ttl_nxt = first_ttl_r - 1'b1;
            phase_nxt   = PH_BACK;
            emit_req    = 1'b1;
          end
        end else if (!cmd_r.is_timex || ttl_over) begin
          emit_done = 1'b1;
        end else begin
          cur_ttl_nxt = ttl_inc[7:0];
          emit_req    = 1'b1;
        end
      end
      default: ;
    endcase

    if (emit_done) phase_nxt = PH_IDLE;

    out_nxt = out_r;
    if (emit_req) begin
      out_nxt.kind             = KIND_PROBE;
      out_nxt.probe_ttl        = cur_ttl_nxt;
      out_nxt.probe_double     = dbl_nxt;
      out_nxt.probe_fixed_flow = fixed_nxt;
      out_nxt.probe_src        = src_nxt;
      out_nxt.probe_dst        = dst_nxt;
      out_nxt.hop_distance     = '0;
      out_nxt.packets_sent     = pkt_nxt;
    end else if (emit_done) begin
      out_nxt.kind             = KIND_DONE;
      out_nxt.probe_ttl        = '0;
      out_nxt.probe_double     = 1'b0;
      out_nxt.probe_fixed_flow = 1'b0;
      out_nxt.probe_src        = '0;
      out_nxt.probe_dst        = '0;
      out_nxt.hop_distance     = done_dist;
      out_nxt.packets_sent     = pkt_nxt;
    end
    out_valid_nxt = (emit_req || emit_done) || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BS_IDLE;
      phase_r      <= PH_IDLE;
      cur_ttl_r    <= '0;
      first_ttl_r  <= '0;
      anon_run_r   <= '0;
      seen_count_r <= '0;
      best_r       <= '0;
      pkt_r        <= '0;
      src_r        <= '0;
      dst_r        <= '0;
      fixed_r      <= 1'b0;
      dbl_r        <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      cur_ttl_r    <= cur_ttl_nxt;
      first_ttl_r  <= first_ttl_nxt;
      anon_run_r   <= anon_run_nxt;
      seen_count_r <= seen_count_nxt;
      best_r       <= best_nxt;
      pkt_r        <= pkt_nxt;
      src_r        <= src_nxt;
      dst_r        <= dst_nxt;
      fixed_r      <= fixed_nxt;
      dbl_r        <= dbl_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) cmd_r <= pop_cmd;
    scan_idx_r <= scan_idx_nxt;
    out_r      <= out_nxt;
  end

  // seen-address store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) seen_mem[seen_count_r[IDX_W-1:0]] <= cmd_r.reply_addr;
    rd_data_r <= seen_mem[rd_idx];
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.kind             = out_r.kind;
  assign out_chan.probe_ttl        = out_r.probe_ttl;
  assign out_chan.probe_double     = out_r.probe_double;
  assign out_chan.probe_fixed_flow = out_r.probe_fixed_flow;
  assign out_chan.probe_src        = out_r.probe_src;
  assign out_chan.probe_dst        = out_r.probe_dst;
  assign out_chan.hop_distance     = out_r.hop_distance;
  assign out_chan.packets_sent     = out_r.packets_sent;

`ifndef ASSERT_OFF
  a_busy_out_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BS_IDLE) |-> !out_valid_r)
    else $error("result register occupied while a word is in work");

  a_seen_bound : assert property (@(posedge clk) disable iff (!rst_n)
    seen_count_r <= CNT_W'(SEEN_DEPTH))
    else $error("seen count past store depth");

  a_scan_fwd : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_SCAN) |-> (phase_r == PH_FWD))
    else $error("address scan outside forward phase");

  a_pend_src : assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ($past(state_r) == BS_SCAN))
    else $error("read pending without a scan");

  a_one_result : assert property (@(posedge clk) disable iff (!rst_n)
    (emit_req || emit_done) |=> (state_r == BS_IDLE) && out_valid_r)
    else $error("result emitted but engine not back to idle");
`endif

endmodule : hds_back
`default_nettype wire

/* hw/rtl/hop_distance_search.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hop_distance_search
// Hop distance estimator steering TTL-limited probes toward a destination.
// ----------------------------------------------------------------------------
// Every accepted word yields exactly one result word: a probe request or a
// finished word with the hop distance. Words pass a one-stage front register
// and a two-entry queue, then the engine. A start, an idle-time result, an
// anonymous forward reply or a backward-phase reply passes only the execute
// state; a non-anonymous forward reply also scans the seen-address store
// through its single registered read port, one address per cycle. While a
// result waits in the result register the engine takes no word, but the front
// keeps taking words until the queue is full. The seen store has no reset;
// only entries written since the last start are ever compared.
// ----------------------------------------------------------------------------
module hop_distance_search #(
  parameter int unsigned MAX_TTL      = hds_pkg::MAX_TTL_DEF,
  parameter int unsigned MAX_ANON_RUN = hds_pkg::MAX_ANON_RUN_DEF,
  parameter int unsigned SEEN_DEPTH   = hds_pkg::SEEN_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hds_in_if.sink    in_chan,
  hds_out_if.source out_chan
);
  import hds_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  hds_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  hds_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  hds_back #(
    .MAX_TTL      (MAX_TTL),
    .MAX_ANON_RUN (MAX_ANON_RUN),
    .SEEN_DEPTH   (SEEN_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .out_chan  (out_chan)
  );

endmodule : hop_distance_search
`default_nettype wire
